### sv/wpcp_pkg.sv
// ----------------------------------------------------------------------------
// wpcp_pkg
// Shared types and constants for the RIFF/WAVE PCM container parser.
// ----------------------------------------------------------------------------
package wpcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned FMT_BODY = 16;
  localparam int unsigned LEN_W    = 33;
  localparam int unsigned POS_W    = 4;

  localparam logic [15:0] FMT_PCM    = 16'd1;
  localparam logic [15:0] BITS_EIGHT = 16'd8;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_HDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RIFF  = 3'd1,
    ST_FMT_SHORT = 3'd2,
    ST_NOT_PCM   = 3'd3,
    ST_NO_FMT    = 3'd4,
    ST_NO_CHAN   = 3'd5,
    ST_TRUNC     = 3'd6
  } status_t;

  typedef struct packed {
    logic        has_sample_byte;
    logic [7:0]  sample_byte;
    logic        verdict_valid;
    status_t     status;
    logic        stereo;
    logic        eight_bit;
    logic [31:0] sample_rate;
  } result_t;

endpackage

### sv/wpcp_parse.sv
// ----------------------------------------------------------------------------
// wpcp_parse
// Byte-wide RIFF/WAVE walker: header check, chunk headers, fmt fields,
// chunk skipping and data pass-through, one byte per accepted beat.
// ----------------------------------------------------------------------------
module wpcp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  input  logic              eof,
  output logic              res_vld,
  output wpcp_pkg::result_t res
);

  wpcp_pkg::phase_t                   phase_r, phase_nxt;
  logic [wpcp_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic [31:0]                        tag_r, tag_nxt;
  logic [wpcp_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic                               fmt_seen_r, fmt_seen_nxt;
  logic [15:0]                        chan_r, chan_nxt;
  logic [15:0]                        bits_r, bits_nxt;
  logic [31:0]                        rate_r, rate_nxt;
  logic [15:0]                        enc_r, enc_nxt;

  logic [31:0]                        tag_base;
  logic [31:0]                        tag_shift;
  logic [wpcp_pkg::LEN_W-1:0]         len_base;
  logic [wpcp_pkg::LEN_W-1:0]         len_asm;
  logic [wpcp_pkg::LEN_W-1:0]         len_pad;
  logic [wpcp_pkg::LEN_W-1:0]         len_dec;
  logic [wpcp_pkg::LEN_W-1:0]         len_fmt;
  logic [wpcp_pkg::POS_W-1:0]         pos_inc;
  logic                               vrd_fire;
  wpcp_pkg::status_t                  vrd_code;
  wpcp_pkg::status_t                  end_code;
  logic                               eof_trunc;

  // shared decode
  always_comb begin
    tag_base  = (phase_r == wpcp_pkg::PH_HDR && pos_r == '0) ? '0 : tag_r;
    tag_shift = {tag_base[23:0], byte_in};
    len_base  = (pos_r == '0) ? '0 : len_r;
    len_asm   = len_base;
    case (pos_r[1:0])
      2'd0:    len_asm[7:0]   = byte_in;
      2'd1:    len_asm[15:8]  = byte_in;
      2'd2:    len_asm[23:16] = byte_in;
      default: len_asm[31:24] = byte_in;
    endcase
    if (pos_r < wpcp_pkg::POS_W'(4)) begin
      len_asm = len_base;
    end
    len_pad = len_asm + {{(wpcp_pkg::LEN_W-1){1'b0}}, len_asm[0]};
    len_dec = len_r - wpcp_pkg::LEN_W'(1);
    len_fmt = len_r - wpcp_pkg::LEN_W'(wpcp_pkg::FMT_BODY);
    pos_inc = pos_r + wpcp_pkg::POS_W'(1);

    if (!fmt_seen_r) begin
      end_code = wpcp_pkg::ST_NO_FMT;
    end else if (chan_r == '0) begin
      end_code = wpcp_pkg::ST_NO_CHAN;
    end else begin
      end_code = wpcp_pkg::ST_OK;
    end

    vrd_fire = 1'b0;
    vrd_code = wpcp_pkg::ST_OK;
    unique case (phase_r)
      wpcp_pkg::PH_RIFF: begin
        if ((pos_r == wpcp_pkg::POS_W'(3) && tag_shift != wpcp_pkg::TAG_RIFF) ||
            (pos_r == wpcp_pkg::POS_W'(11) && tag_shift != wpcp_pkg::TAG_WAVE)) begin
          vrd_fire = 1'b1;
          vrd_code = wpcp_pkg::ST_BAD_RIFF;
        end
      end
      wpcp_pkg::PH_HDR: begin
        if (pos_r == wpcp_pkg::POS_W'(7)) begin
          if (tag_r == wpcp_pkg::TAG_FMT &&
              len_asm < wpcp_pkg::LEN_W'(wpcp_pkg::FMT_BODY)) begin
            vrd_fire = 1'b1;
            vrd_code = wpcp_pkg::ST_FMT_SHORT;
          end else if (tag_r == wpcp_pkg::TAG_DATA && len_asm == '0) begin
            vrd_fire = 1'b1;
            vrd_code = end_code;
          end
        end
      end
      wpcp_pkg::PH_FMT: begin
        if (pos_r == wpcp_pkg::POS_W'(15) && enc_r != wpcp_pkg::FMT_PCM) begin
          vrd_fire = 1'b1;
          vrd_code = wpcp_pkg::ST_NOT_PCM;
        end
      end
      wpcp_pkg::PH_DATA: begin
        if (len_dec == '0) begin
          vrd_fire = 1'b1;
          vrd_code = end_code;
        end
      end
      default: begin
      end
    endcase

    eof_trunc = eof && !vrd_fire && phase_r != wpcp_pkg::PH_DONE;
  end

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    fmt_seen_nxt = fmt_seen_r;
    chan_nxt     = chan_r;
    bits_nxt     = bits_r;
    rate_nxt     = rate_r;
    enc_nxt      = enc_r;
    unique case (phase_r)
      wpcp_pkg::PH_RIFF: begin
        pos_nxt = pos_inc;
        if (pos_r < wpcp_pkg::POS_W'(4) || pos_r >= wpcp_pkg::POS_W'(8)) begin
          tag_nxt = tag_shift;
        end
        if (pos_r == wpcp_pkg::POS_W'(3)) begin
          tag_nxt = '0;
        end
        if (pos_r == wpcp_pkg::POS_W'(11)) begin
          phase_nxt = wpcp_pkg::PH_HDR;
          pos_nxt   = '0;
          tag_nxt   = '0;
        end
      end
      wpcp_pkg::PH_HDR: begin
        tag_nxt = (pos_r < wpcp_pkg::POS_W'(4)) ? tag_shift : tag_base;
        len_nxt = len_asm;
        pos_nxt = pos_inc;
        if (pos_r == wpcp_pkg::POS_W'(7)) begin
          pos_nxt = '0;
          if (tag_r == wpcp_pkg::TAG_FMT) begin
            phase_nxt = wpcp_pkg::PH_FMT;
          end else if (tag_r == wpcp_pkg::TAG_DATA) begin
            phase_nxt = wpcp_pkg::PH_DATA;
          end else begin
            len_nxt   = len_pad;
            phase_nxt = (len_pad == '0) ? wpcp_pkg::PH_HDR : wpcp_pkg::PH_SKIP;
          end
        end
      end
      wpcp_pkg::PH_FMT: begin
        case (pos_r)
          4'd0:    enc_nxt  = {8'd0, byte_in};
          4'd1:    enc_nxt  = {byte_in, enc_r[7:0]};
          4'd2:    chan_nxt = {8'd0, byte_in};
          4'd3:    chan_nxt = {byte_in, chan_r[7:0]};
          4'd4:    rate_nxt = {24'd0, byte_in};
          4'd5:    rate_nxt = {16'd0, byte_in, rate_r[7:0]};
          4'd6:    rate_nxt = {8'd0, byte_in, rate_r[15:0]};
          4'd7:    rate_nxt = {byte_in, rate_r[23:0]};
          4'd14:   bits_nxt = {8'd0, byte_in};
          4'd15:   bits_nxt = {byte_in, bits_r[7:0]};
          default: begin
          end
        endcase
        pos_nxt = pos_inc;
        if (pos_r == wpcp_pkg::POS_W'(15)) begin
          fmt_seen_nxt = 1'b1;
          len_nxt      = len_fmt;
          phase_nxt    = (len_fmt == '0) ? wpcp_pkg::PH_HDR : wpcp_pkg::PH_SKIP;
        end
      end
      wpcp_pkg::PH_SKIP: begin
        len_nxt = len_dec;
        if (len_dec == '0) begin
          phase_nxt = wpcp_pkg::PH_HDR;
          pos_nxt   = '0;
        end
      end
      wpcp_pkg::PH_DATA: begin
        len_nxt = len_dec;
      end
      default: begin
      end
    endcase
    if (vrd_fire) begin
      phase_nxt = wpcp_pkg::PH_DONE;
    end
    if (eof) begin
      phase_nxt    = wpcp_pkg::PH_RIFF;
      pos_nxt      = '0;
      fmt_seen_nxt = 1'b0;
    end
  end

  // result
  always_comb begin
    res                 = '0;
    res.has_sample_byte = (phase_r == wpcp_pkg::PH_DATA);
    res.sample_byte     = (phase_r == wpcp_pkg::PH_DATA) ? byte_in : 8'd0;
    if (vrd_fire) begin
      res.verdict_valid = 1'b1;
      res.status        = vrd_code;
      if (vrd_code == wpcp_pkg::ST_OK) begin
        res.stereo      = (chan_r != 16'd1);
        res.eight_bit   = (bits_r == wpcp_pkg::BITS_EIGHT);
        res.sample_rate = rate_r;
      end
    end else if (eof_trunc) begin
      res.verdict_valid = 1'b1;
      res.status        = wpcp_pkg::ST_TRUNC;
    end
    res_vld = fire && (res.has_sample_byte || res.verdict_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wpcp_pkg::PH_RIFF;
      pos_r      <= '0;
      fmt_seen_r <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      fmt_seen_r <= fmt_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tag_r  <= tag_nxt;
      len_r  <= len_nxt;
      chan_r <= chan_nxt;
      bits_r <= bits_nxt;
      rate_r <= rate_nxt;
      enc_r  <= enc_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fire && eof |=> phase_r == wpcp_pkg::PH_RIFF && pos_r == '0 && !fmt_seen_r)
    else $error("parser did not re-arm after end of file");

  assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == wpcp_pkg::PH_DONE && !eof |-> !res_vld)
    else $error("result produced after verdict");

  assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.verdict_valid && res.status != wpcp_pkg::ST_OK
      |-> !res.stereo && !res.eight_bit && res.sample_rate == '0)
    else $error("format fields set on failing verdict");

endmodule

### sv/wpcp_out_buf.sv
// ----------------------------------------------------------------------------
// wpcp_out_buf
// Result register with a skid slot; upstream stall comes from a flop.
// ----------------------------------------------------------------------------
module wpcp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wpcp_pkg::result_t push_res,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output wpcp_pkg::result_t out_res
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  wpcp_pkg::result_t out_res_r, out_res_nxt;
  wpcp_pkg::result_t skid_res_r, skid_res_nxt;
  logic              pop;

  always_comb begin
    pop            = out_valid_r && !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a beat ahead of the output register");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |=> !skid_valid_r)
    else $error("skid slot filled while output register was empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid beat not moved forward");

endmodule

### sv/wav_pcm_container_parser.sv
// ----------------------------------------------------------------------------
// wav_pcm_container_parser
// RIFF/WAVE PCM container parser: checks the file header, walks chunks,
// keeps the PCM format, passes data chunk bytes and gives one verdict.
//
//   channel  direction  beat
//   in_      input      one file byte, end-of-file mark on the last byte
//   out_     output     data byte and/or the file verdict
//
// one byte accepted per cycle while in_stall is low; the parse step is
// combinational logic between the state registers and the result register
// a result reaches the out_ ports via the result register or its skid slot
// reset is synchronous; no clearing pass follows
// in_stall is a flop: it rises once the result register and its skid slot
// both hold beats, and falls the cycle after out_stall releases
// ----------------------------------------------------------------------------
module wav_pcm_container_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_input_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_sample_byte,
  output logic [7:0]  out_sample_byte,
  output logic        out_verdict_valid,
  output logic [2:0]  out_status,
  output logic        out_stereo,
  output logic        out_eight_bit,
  output logic [31:0] out_sample_rate
);

  logic              in_fire;
  logic              res_vld;
  logic              buf_full;
  wpcp_pkg::result_t res;
  wpcp_pkg::result_t out_res;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  wpcp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .byte_in (in_input_byte),
    .eof     (in_end_of_file),
    .res_vld (res_vld),
    .res     (res)
  );

  wpcp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_has_sample_byte = out_res.has_sample_byte;
  assign out_sample_byte     = out_res.sample_byte;
  assign out_verdict_valid   = out_res.verdict_valid;
  assign out_status          = out_res.status;
  assign out_stereo          = out_res.stereo;
  assign out_eight_bit       = out_res.eight_bit;
  assign out_sample_rate     = out_res.sample_rate;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RIFF/WAVE PCM container parser. Short directed
// files hit the header errors, then random files walk every parse path:
// good PCM files, missing or short or non-PCM fmt chunks, broken tags, huge
// chunk sizes cut off by end of file, and raw noise. A tracker class mirrors
// the parser per accepted byte and checks each output beat in order. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  class wav_verdict_tracker;
    wpcp_pkg::phase_t  step_phase;
    logic [31:0]       byte_pos;
    logic [31:0]       tag_word;
    logic [32:0]       chunk_left;
    logic              fmt_ok;
    logic [15:0]       chans;
    logic [15:0]       bits;
    logic [15:0]       enc;
    logic [31:0]       rate;
    logic              verdict_done;
    wpcp_pkg::result_t due_results[$];
    int                mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      step_phase   = wpcp_pkg::PH_RIFF;
      byte_pos     = '0;
      tag_word     = '0;
      chunk_left   = '0;
      fmt_ok       = 1'b0;
      chans        = '0;
      bits         = '0;
      enc          = '0;
      rate         = '0;
      verdict_done = 1'b0;
    endfunction

    function void close_file(inout wpcp_pkg::result_t r, input wpcp_pkg::status_t st);
      r.verdict_valid = 1'b1;
      r.status        = st;
      if (st == wpcp_pkg::ST_OK) begin
        r.stereo      = (chans != 16'd1);
        r.eight_bit   = (bits == wpcp_pkg::BITS_EIGHT);
        r.sample_rate = rate;
      end
      verdict_done = 1'b1;
      step_phase   = wpcp_pkg::PH_DONE;
    endfunction

    function void close_data(inout wpcp_pkg::result_t r);
      if (!fmt_ok) begin
        close_file(r, wpcp_pkg::ST_NO_FMT);
      end else if (chans == 16'd0) begin
        close_file(r, wpcp_pkg::ST_NO_CHAN);
      end else begin
        close_file(r, wpcp_pkg::ST_OK);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      wpcp_pkg::result_t r;
      r = '0;
      case (step_phase)
        wpcp_pkg::PH_RIFF: begin
          if (byte_pos < 4 || byte_pos >= 8) tag_word = {tag_word[23:0], b};
          byte_pos++;
          if (byte_pos == 4) begin
            if (tag_word != wpcp_pkg::TAG_RIFF) close_file(r, wpcp_pkg::ST_BAD_RIFF);
            tag_word = '0;
          end else if (byte_pos == 12) begin
            if (tag_word != wpcp_pkg::TAG_WAVE) begin
              close_file(r, wpcp_pkg::ST_BAD_RIFF);
            end else begin
              step_phase = wpcp_pkg::PH_HDR;
              byte_pos   = '0;
              tag_word   = '0;
            end
          end
        end
        wpcp_pkg::PH_HDR: begin
          if (byte_pos == 0) begin
            tag_word   = '0;
            chunk_left = '0;
          end
          if (byte_pos < 4) begin
            tag_word = {tag_word[23:0], b};
          end else begin
            chunk_left = chunk_left | ({25'd0, b} << (8 * byte_pos[1:0]));
          end
          byte_pos++;
          if (byte_pos >= 8) begin
            byte_pos = '0;
            if (tag_word == wpcp_pkg::TAG_FMT) begin
              if (chunk_left < wpcp_pkg::FMT_BODY) close_file(r, wpcp_pkg::ST_FMT_SHORT);
              else step_phase = wpcp_pkg::PH_FMT;
            end else if (tag_word == wpcp_pkg::TAG_DATA) begin
              if (chunk_left == 0) close_data(r);
              else step_phase = wpcp_pkg::PH_DATA;
            end else begin
              chunk_left = chunk_left + chunk_left[0];
              step_phase = (chunk_left == 0) ? wpcp_pkg::PH_HDR : wpcp_pkg::PH_SKIP;
            end
          end
        end
        wpcp_pkg::PH_FMT: begin
          case (byte_pos)
            32'd0:  enc = {8'h00, b};
            32'd1:  enc[15:8] = b;
            32'd2:  chans = {8'h00, b};
            32'd3:  chans[15:8] = b;
            32'd4:  rate = {24'd0, b};
            32'd5:  rate[15:8] = b;
            32'd6:  rate[23:16] = b;
            32'd7:  rate[31:24] = b;
            32'd14: bits = {8'h00, b};
            32'd15: bits[15:8] = b;
            default: ;
          endcase
          byte_pos++;
          if (byte_pos >= wpcp_pkg::FMT_BODY) begin
            byte_pos = '0;
            if (enc != wpcp_pkg::FMT_PCM) begin
              close_file(r, wpcp_pkg::ST_NOT_PCM);
            end else begin
              fmt_ok     = 1'b1;
              chunk_left = chunk_left - 33'(wpcp_pkg::FMT_BODY);
              step_phase = (chunk_left == 0) ? wpcp_pkg::PH_HDR : wpcp_pkg::PH_SKIP;
            end
          end
        end
        wpcp_pkg::PH_SKIP: begin
          if (chunk_left != 0) chunk_left--;
          if (chunk_left == 0) begin
            step_phase = wpcp_pkg::PH_HDR;
            byte_pos   = '0;
          end
        end
        wpcp_pkg::PH_DATA: begin
          r.has_sample_byte = 1'b1;
          r.sample_byte     = b;
          if (chunk_left != 0) chunk_left--;
          if (chunk_left == 0) close_data(r);
        end
        default: ;
      endcase
      if (eof) begin
        if (!verdict_done) close_file(r, wpcp_pkg::ST_TRUNC);
        clear();
      end
      if (r.has_sample_byte || r.verdict_valid) due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(wpcp_pkg::result_t got);
      wpcp_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare_field("has_sample_byte", want.has_sample_byte, got.has_sample_byte);
      compare_field("sample_byte", want.sample_byte, got.sample_byte);
      compare_field("verdict_valid", want.verdict_valid, got.verdict_valid);
      compare_field("status", want.status, got.status);
      compare_field("stereo", want.stereo, got.stereo);
      compare_field("eight_bit", want.eight_bit, got.eight_bit);
      compare_field("sample_rate", want.sample_rate, got.sample_rate);
    endfunction

    function void check_leftover();
      if (due_results.size() != 0) begin
        $error("%0d expected result beats never arrived", due_results.size());
        mismatches++;
      end
    endfunction
  endclass

  typedef enum int {
    FK_GOOD,
    FK_NO_FMT,
    FK_SHORT_FMT,
    FK_NOT_PCM,
    FK_BAD_TAG,
    FK_HUGE,
    FK_NOISE
  } file_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_input_byte = '0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_has_sample_byte;
  logic [7:0]  out_sample_byte;
  logic        out_verdict_valid;
  logic [2:0]  out_status;
  logic        out_stereo;
  logic        out_eight_bit;
  logic [31:0] out_sample_rate;

  wav_verdict_tracker board = new();
  logic [7:0]  file_q[$];
  logic        steady_in = 1'b0;
  logic        steady_out = 1'b0;
  int          out_hold = 0;
  wpcp_pkg::result_t seen_beat;

  wav_pcm_container_parser u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_input_byte       (in_input_byte),
    .in_end_of_file      (in_end_of_file),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_has_sample_byte (out_has_sample_byte),
    .out_sample_byte     (out_sample_byte),
    .out_verdict_valid   (out_verdict_valid),
    .out_status          (out_status),
    .out_stereo          (out_stereo),
    .out_eight_bit       (out_eight_bit),
    .out_sample_rate     (out_sample_rate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_beat.has_sample_byte = out_has_sample_byte;
        seen_beat.sample_byte     = out_sample_byte;
        seen_beat.verdict_valid   = out_verdict_valid;
        seen_beat.status          = wpcp_pkg::status_t'(out_status);
        seen_beat.stereo          = out_stereo;
        seen_beat.eight_bit       = out_eight_bit;
        seen_beat.sample_rate     = out_sample_rate;
        board.check_result(seen_beat);
        out_hold = steady_out ? 0 : $urandom_range(0, 3);
        out_stall <= (out_hold != 0);
      end else if (out_hold != 0) begin
        out_hold--;
        out_stall <= (out_hold != 0);
      end
    end
  end

  function automatic void put_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_q.push_back(t[8*i +: 8]);
  endfunction

  function automatic void put_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_le16(logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endfunction

  function automatic void put_noise(int n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] other_tag();
    logic [31:0] t;
    t = $urandom;
    if (t == wpcp_pkg::TAG_FMT || t == wpcp_pkg::TAG_DATA) t = t ^ 32'd1;
    return t;
  endfunction

  function automatic logic [15:0] pick_chans();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_bits();
    case ($urandom_range(0, 2))
      0: return wpcp_pkg::BITS_EIGHT;
      1: return 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void put_riff_header();
    put_tag(wpcp_pkg::TAG_RIFF);
    put_le32($urandom);
    put_tag(wpcp_pkg::TAG_WAVE);
  endfunction

  function automatic void put_fmt(logic [31:0] size, logic [15:0] code, logic [15:0] chan_n,
                                  logic [31:0] hz, logic [15:0] width);
    put_tag(wpcp_pkg::TAG_FMT);
    put_le32(size);
    put_le16(code);
    put_le16(chan_n);
    put_le32(hz);
    put_noise(6);
    put_le16(width);
    if (size > 16 && size < 64) put_noise(size - 16);
  endfunction

  function automatic void put_other_chunk();
    int n;
    n = $urandom_range(0, 7);
    put_tag(other_tag());
    put_le32(n);
    put_noise(n + n % 2);
  endfunction

  function automatic void put_data(int n);
    put_tag(wpcp_pkg::TAG_DATA);
    put_le32(n);
    put_noise(n);
  endfunction

  task automatic push_byte(logic [7:0] b, logic eof);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_input_byte  <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    board.note_byte(b, eof);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) push_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due_results.size() != 0);
  endtask

  initial begin
    int          sent;
    int          files;
    int          pick;
    int          cut;
    file_kind_t  kind;
    logic [15:0] code;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // end of file on the very first byte
    file_q.push_back(8'hFF);
    send_file();
    // bad riff tag, then bytes that must be ignored
    put_tag(32'h5249_4658);
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    send_file();
    // bad wave tag
    put_tag(wpcp_pkg::TAG_RIFF);
    put_le32(32'd0);
    put_tag(32'h5741_5646);
    send_file();
    wait_for_drain();

    sent  = 0;
    files = 0;
    while (sent < 450 || files <= FK_NOISE) begin
      steady_in = ($urandom_range(0, 3) == 0);
      steady_out <= ($urandom_range(0, 3) == 0);
      if (files <= FK_NOISE) begin
        kind = file_kind_t'(files);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) kind = FK_GOOD;
        else if (pick < 58) kind = FK_NO_FMT;
        else if (pick < 66) kind = FK_SHORT_FMT;
        else if (pick < 74) kind = FK_NOT_PCM;
        else if (pick < 84) kind = FK_BAD_TAG;
        else if (pick < 93) kind = FK_HUGE;
        else kind = FK_NOISE;
      end
      case (kind)
        FK_GOOD: begin
          put_riff_header();
          repeat ($urandom_range(0, 2)) put_other_chunk();
          put_fmt(($urandom_range(0, 3) == 0) ? 16 + $urandom_range(1, 5) : 16,
                  wpcp_pkg::FMT_PCM, pick_chans(), $urandom, pick_bits());
          if ($urandom_range(0, 4) == 0) begin
            put_other_chunk();
            put_fmt(16, wpcp_pkg::FMT_PCM, pick_chans(), $urandom, pick_bits());
          end
          if ($urandom_range(0, 3) == 0) put_other_chunk();
          put_data(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 16));
          put_noise($urandom_range(0, 3));
        end
        FK_NO_FMT: begin
          put_riff_header();
          if ($urandom_range(0, 1) == 0) put_other_chunk();
          put_data($urandom_range(0, 8));
          put_noise($urandom_range(0, 2));
        end
        FK_SHORT_FMT: begin
          put_riff_header();
          put_tag(wpcp_pkg::TAG_FMT);
          put_le32($urandom_range(0, 15));
          put_noise($urandom_range(0, 4));
        end
        FK_NOT_PCM: begin
          put_riff_header();
          code = 16'($urandom);
          if (code == wpcp_pkg::FMT_PCM) code = 16'd0;
          put_fmt(16, code, pick_chans(), $urandom, pick_bits());
          put_noise($urandom_range(0, 3));
        end
        FK_BAD_TAG: begin
          put_riff_header();
          pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(8, 11);
          file_q[pick] = file_q[pick] ^ (8'h01 << $urandom_range(0, 7));
          put_noise($urandom_range(0, 4));
        end
        FK_HUGE: begin
          put_riff_header();
          case ($urandom_range(0, 2))
            0: begin
              put_fmt(16, wpcp_pkg::FMT_PCM, pick_chans(), $urandom, pick_bits());
              put_tag(wpcp_pkg::TAG_DATA);
              put_le32(32'hFFFF_FFFF - $urandom_range(0, 1));
            end
            1: begin
              put_tag(other_tag());
              put_le32(32'hFFFF_FFFF - $urandom_range(0, 1));
            end
            default: begin
              put_fmt(32'hFFFF_FFFF - $urandom_range(0, 1), wpcp_pkg::FMT_PCM, pick_chans(),
                      $urandom, pick_bits());
            end
          endcase
          put_noise($urandom_range(1, 10));
        end
        default: put_noise($urandom_range(1, 20));
      endcase
      if (kind != FK_NOISE && $urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
      sent += file_q.size();
      files++;
      send_file();
      if ($urandom_range(0, 9) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (8) @(posedge clk);
    board.check_leftover();
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/wpcp_pkg.sv
sv/wpcp_parse.sv
sv/wpcp_out_buf.sv
sv/wav_pcm_container_parser.sv
sim/tb.sv
